// ----- rtl/dlpse_pkg.sv -----
// Shared types and constants for the display-list page-split encoder.
// No dependencies; used by every module of the block.
`default_nettype none

package dlpse_pkg;

  // Item field widths
  localparam int ADDR_W  = 16;
  localparam int COUNT_W = 8;
  localparam int MODE_W  = 4;
  localparam int BLANK_W = 8;
  localparam int NB_W    = BLANK_W - 3;   // blank-8 groups
  localparam int OP_W    = 8;
  localparam int SIZE_W  = 16;

  // Screen geometry: a page is 2**PAGE_SHIFT bytes, a line LINE_BYTES bytes
  localparam int PAGE_SHIFT = 12;
  localparam int LINE_BYTES = 40;

  // Line-count unit: bytes left in a page (up to one full page) over the line size,
  // by a rounded-up reciprocal that is exact over that range
  localparam int QUOT_W      = COUNT_W;
  localparam int REM_W       = PAGE_SHIFT + 1;
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = QUOT_W + RECIP_SHIFT - REM_W;
  localparam logic [RECIP_W-1:0] RECIP_MUL =
    RECIP_W'((2 ** RECIP_SHIFT + LINE_BYTES - 1) / LINE_BYTES);

  // Result slots per item
  localparam int MAX_RESULTS = 12;
  localparam int SLOT_W      = 4;

  // Instruction bytes
  localparam logic [OP_W-1:0] OP_BLANK8 = 8'h70;
  localparam logic [OP_W-1:0] OP_JVB    = 8'h41;
  localparam logic [OP_W-1:0] BIT_LMS   = 8'h40;
  localparam logic [OP_W-1:0] BIT_DLI   = 8'h80;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHUNK,
    ST_DIV,
    ST_BLANK,
    ST_LMS,
    ST_RUN,
    ST_JUMP
  } state_t;

  // One result item offered to the output register
  typedef struct packed {
    logic              valid;
    logic [OP_W-1:0]   opcode;
    logic              has_address;
    logic [ADDR_W-1:0] operand_address;
    logic [COUNT_W-1:0] repeat_res;
    logic [SIZE_W-1:0] list_size;
    logic              last_of_run;
  } emit_t;

endpackage

`default_nettype wire

// ----- rtl/dlpse_div.sv -----
// Line-count unit: bytes left in a page divided by the line size, by reciprocal multiply.
// Result registered on start, ready the next cycle; depends on dlpse_pkg.
`default_nettype none

module dlpse_div (
  input  wire logic                          clk,
  input  wire logic                          start,
  input  wire logic [dlpse_pkg::REM_W-1:0]   dividend,
  output logic      [dlpse_pkg::QUOT_W-1:0]  quot
);
  import dlpse_pkg::*;

  logic [QUOT_W-1:0]        quot_r, quot_nxt;
  logic [REM_W+RECIP_W-1:0] product;

  // floor(dividend / LINE_BYTES) taken from the top bits of the product
  assign product = {{RECIP_W{1'b0}}, dividend} * {{REM_W{1'b0}}, RECIP_MUL};

  always_comb begin
    quot_nxt = quot_r;
    if (start) begin
      quot_nxt = product[RECIP_SHIFT +: QUOT_W];
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
  end

  assign quot = quot_r;

endmodule

`default_nettype wire

// ----- rtl/dlpse_ctrl.sv -----
// Sequencer and datapath: splits a segment into page chunks and offers result items.
// Uses dlpse_pkg and one dlpse_div instance.
`default_nettype none

module dlpse_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [dlpse_pkg::BLANK_W-1:0]   in_blank_scans,
  input  wire logic [dlpse_pkg::MODE_W-1:0]    in_mode,
  input  wire logic [dlpse_pkg::COUNT_W-1:0]   in_mode_rows,
  input  wire logic                            in_dli_enable,
  input  wire logic [dlpse_pkg::ADDR_W-1:0]    in_screen_address,
  input  wire logic                            in_last_segment,
  input  wire logic [dlpse_pkg::ADDR_W-1:0]    list_base,
  input  wire logic                            out_free,
  output dlpse_pkg::emit_t                     emit
);
  import dlpse_pkg::*;

  state_t             state_r, state_nxt;
  logic [NB_W-1:0]    nb_r, nb_nxt;
  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               dli_r, dli_nxt;
  logic               last_r, last_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [ADDR_W-1:0]  bound_r, bound_nxt;
  logic [COUNT_W-1:0] done_r, done_nxt;
  logic [COUNT_W-1:0] lines_r, lines_nxt;
  logic               first_r, first_nxt;
  logic [SLOT_W-1:0]  n_r, n_nxt;
  logic [SIZE_W-1:0]  bt_r, bt_nxt;

  logic                   accept;
  logic [ADDR_W-PAGE_SHIFT:0] page_hi;
  logic [ADDR_W:0]        bound_w;
  logic [ADDR_W:0]        gap_w;
  logic [QUOT_W-1:0]      quot;
  logic                   div_start;
  logic [COUNT_W-1:0]     rows_left;
  logic [COUNT_W-1:0]     lines_c;
  logic [NB_W-1:0]        nb_eff;
  logic [OP_W-1:0]        base_op;
  logic                   has_lms;
  logic [COUNT_W-1:0]     run_cnt;
  logic                   more;
  logic [SLOT_W-1:0]      cap;
  logic                   room;
  logic                   want;
  logic                   final_piece;
  logic                   adv;
  logic [COUNT_W:0]       addend;
  logic [SIZE_W:0]        sum_w;
  logic [SIZE_W-1:0]      sat_sum;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Next page boundary and bytes left before it
  assign page_hi = {1'b0, addr_r[ADDR_W-1:PAGE_SHIFT]} + 1'b1;
  assign bound_w = {page_hi, {PAGE_SHIFT{1'b0}}};
  assign gap_w   = bound_w - {1'b0, addr_r};

  assign div_start = (state_r == ST_CHUNK);

  dlpse_div u_div (
    .clk      (clk),
    .start    (div_start),
    .dividend (gap_w[REM_W-1:0]),
    .quot     (quot)
  );

  // Lines in this chunk: those that fit before the boundary, at most the rest
  assign rows_left = count_r - done_r;
  always_comb begin
    lines_c = (quot < rows_left) ? quot : rows_left;
    if (!first_r && (lines_c == '0)) begin
      lines_c = COUNT_W'(1);
    end
  end

  // Chunk decode
  assign nb_eff  = first_r ? nb_r : '0;
  assign base_op = OP_W'(mode_r) | ((first_r && dli_r) ? BIT_DLI : '0);
  assign has_lms = (lines_r != '0) && (addr_r != '0);
  assign run_cnt = has_lms ? lines_r - 1'b1 : lines_r;
  assign more    = ({1'b0, done_r} + {1'b0, lines_r}) < {1'b0, count_r};
  assign cap     = last_r ? SLOT_W'(MAX_RESULTS - 1) : SLOT_W'(MAX_RESULTS);
  assign room    = (n_r < cap);

  // Shared saturating byte adder
  assign sum_w   = {1'b0, bt_r} + (SIZE_W + 1)'(addend);
  assign sat_sum = sum_w[SIZE_W] ? '1 : sum_w[SIZE_W-1:0];

  // Outputs: the piece offered in each state
  always_comb begin
    want                 = 1'b0;
    final_piece          = 1'b0;
    addend               = '0;
    emit                 = '0;
    case (state_r)
      ST_BLANK: begin
        want            = (nb_eff != '0);
        final_piece     = (lines_r == '0) && !more;
        addend          = (COUNT_W + 1)'(nb_eff);
        emit.opcode     = OP_BLANK8;
        emit.repeat_res = COUNT_W'(nb_eff);
      end
      ST_LMS: begin
        want                 = has_lms;
        final_piece          = (run_cnt == '0) && !more;
        addend               = has_lms ? (COUNT_W + 1)'(2) : '0;
        emit.opcode          = base_op | BIT_LMS;
        emit.has_address     = 1'b1;
        emit.operand_address = addr_r;
        emit.repeat_res      = COUNT_W'(1);
      end
      ST_RUN: begin
        want            = (run_cnt != '0);
        final_piece     = !more;
        addend          = (COUNT_W + 1)'(lines_r);
        emit.opcode     = base_op;
        emit.repeat_res = run_cnt;
      end
      ST_JUMP: begin
        want                 = 1'b1;
        final_piece          = 1'b1;
        addend               = (COUNT_W + 1)'(3);
        emit.opcode          = OP_JVB;
        emit.has_address     = 1'b1;
        emit.operand_address = list_base;
        emit.repeat_res      = COUNT_W'(1);
        emit.list_size       = sat_sum;
      end
      default: begin
        want = 1'b0;
      end
    endcase
    emit.valid       = want && (room || (state_r == ST_JUMP));
    emit.last_of_run = last_r ? (state_r == ST_JUMP)
                              : (final_piece || (n_r == SLOT_W'(MAX_RESULTS - 1)));
    adv              = !emit.valid || out_free;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode_rows != '0) begin
            state_nxt = ST_CHUNK;
          end else if (in_last_segment) begin
            state_nxt = ST_JUMP;
          end
        end
      end
      ST_CHUNK: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        state_nxt = ST_BLANK;
      end
      ST_BLANK: begin
        if (adv) begin
          state_nxt = ST_LMS;
        end
      end
      ST_LMS: begin
        if (adv) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (adv) begin
          if (more) begin
            state_nxt = ST_CHUNK;
          end else if (last_r) begin
            state_nxt = ST_JUMP;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_JUMP: begin
        if (adv) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath register updates
  always_comb begin
    nb_nxt    = nb_r;
    mode_nxt  = mode_r;
    count_nxt = count_r;
    dli_nxt   = dli_r;
    last_nxt  = last_r;
    addr_nxt  = addr_r;
    bound_nxt = bound_r;
    done_nxt  = done_r;
    lines_nxt = lines_r;
    first_nxt = first_r;
    n_nxt     = n_r;
    bt_nxt    = bt_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          nb_nxt    = in_blank_scans[BLANK_W-1:3];
          mode_nxt  = in_mode;
          count_nxt = in_mode_rows;
          dli_nxt   = in_dli_enable;
          last_nxt  = in_last_segment;
          addr_nxt  = in_screen_address;
          done_nxt  = '0;
          first_nxt = 1'b1;
          n_nxt     = '0;
        end
      end
      ST_CHUNK: begin
        bound_nxt = bound_w[ADDR_W-1:0];
      end
      ST_DIV: begin
        lines_nxt = lines_c;
      end
      ST_BLANK, ST_LMS, ST_RUN: begin
        if (adv) begin
          bt_nxt = sat_sum;
          if (emit.valid) begin
            n_nxt = n_r + 1'b1;
          end
          if (state_r == ST_RUN) begin
            done_nxt  = done_r + lines_r;
            addr_nxt  = bound_r;
            first_nxt = 1'b0;
          end
        end
      end
      ST_JUMP: begin
        if (adv) begin
          bt_nxt = '0;
        end
      end
      default: begin
        bt_nxt = bt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      bt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      bt_r    <= bt_nxt;
    end
    nb_r    <= nb_nxt;
    mode_r  <= mode_nxt;
    count_r <= count_nxt;
    dli_r   <= dli_nxt;
    last_r  <= last_nxt;
    addr_r  <= addr_nxt;
    bound_r <= bound_nxt;
    done_r  <= done_nxt;
    lines_r <= lines_nxt;
    first_r <= first_nxt;
    n_r     <= n_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/display_list_page_split_encoder_top.sv -----
// Display-list page-split encoder: one segment item in, up to 12 instruction run items out.
// An item is held while it is worked on; a new one is taken once the last result has been
// offered. A segment is taken, then each 4 KB page chunk runs a setup step, the reciprocal
// line count and 3 emit steps, each emit step held while the output is stalled, and a
// last segment ends with the closing jump. Up to four chunks per item.
// Holds the base-address register and the output register; uses dlpse_pkg and dlpse_ctrl.
`default_nettype none

module display_list_page_split_encoder_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration
  input  wire logic                            cfg_wr_en,
  input  wire logic [dlpse_pkg::ADDR_W-1:0]    cfg_wr_data,
  // segment items
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [dlpse_pkg::BLANK_W-1:0]   in_blank_scans,
  input  wire logic [dlpse_pkg::MODE_W-1:0]    in_mode,
  input  wire logic [dlpse_pkg::COUNT_W-1:0]   in_mode_rows,
  input  wire logic                            in_dli_enable,
  input  wire logic [dlpse_pkg::ADDR_W-1:0]    in_screen_address,
  input  wire logic                            in_last_segment,
  // result items
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [dlpse_pkg::OP_W-1:0]           out_opcode,
  output logic                                 out_has_address,
  output logic [dlpse_pkg::ADDR_W-1:0]         out_operand_address,
  output logic [dlpse_pkg::COUNT_W-1:0]        out_repeat_res,
  output logic [dlpse_pkg::SIZE_W-1:0]         out_list_size,
  output logic                                 out_last_of_run
);
  import dlpse_pkg::*;

  logic [ADDR_W-1:0] base_r;
  logic              out_valid_r;
  emit_t             hold_r;
  emit_t             emit;
  logic              out_free;

  // Jump target register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (cfg_wr_en) begin
      base_r <= cfg_wr_data;
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  dlpse_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_blank_scans    (in_blank_scans),
    .in_mode           (in_mode),
    .in_mode_rows      (in_mode_rows),
    .in_dli_enable     (in_dli_enable),
    .in_screen_address (in_screen_address),
    .in_last_segment   (in_last_segment),
    .list_base         (base_r),
    .out_free          (out_free),
    .emit              (emit)
  );

  // Output register: loads when free, holds while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (emit.valid && out_free) begin
      hold_r <= emit;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_opcode          = hold_r.opcode;
  assign out_has_address     = hold_r.has_address;
  assign out_operand_address = hold_r.operand_address;
  assign out_repeat_res      = hold_r.repeat_res;
  assign out_list_size       = hold_r.list_size;
  assign out_last_of_run     = hold_r.last_of_run;

endmodule

`default_nettype wire
